>>> sv/hardware_monitor_registers_macros.svh
// Assertion macros shared by the monitor modules.
// Needs clk and arst_n in the scope of each use.
`ifndef HARDWARE_MONITOR_REGISTERS_MACROS_SVH
`define HARDWARE_MONITOR_REGISTERS_MACROS_SVH
`ifndef SYNTHESIS
`define HMR_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hmr assertion failed");
`define HMR_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hmr assertion failed");
`else
`define HMR_ASSERT_IMP(lbl, ante, cons)
`define HMR_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/hmr_pkg.sv
// Types, constants and conversion tables of the hardware monitor.
// Used by hmr_ctrl, hmr_dp and hardware_monitor_registers.
package hmr_pkg;

	localparam int OffW = 7;
	localparam int RegDepth = 128;
	localparam int SensW = 17;
	localparam int NumSens = 10;
	localparam int SelW = 4;
	localparam int InW = 40;
	localparam int NumW = 36;
	localparam int DivW = 21;
	localparam int RemW = DivW + 8;
	localparam logic [NumW-1:0] FAN_CONST = NumW'(1350000);
	localparam logic [DivW-1:0] VOLT_DIV = DivW'(1638400);
	localparam logic signed [NumW:0] VOLT_OFF = (NumW+1)'(7897088);

	typedef enum logic [1:0] {
		ACT_READ = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_UPDATE = 2'd2,
		ACT_NOP = 2'd3
	} act_t;

	typedef enum logic [1:0] {
		KIND_PLAIN = 2'd0,
		KIND_TEMP = 2'd1,
		KIND_VOLT = 2'd2,
		KIND_FAN = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PREP,
		ST_CHECK,
		ST_DIV,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic fetch;
		logic prep;
		logic check;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic direct;
		logic prep_done;
		logic check_done;
		logic out_full;
		logic is_read;
	} sts_t;

	typedef logic [7:0] tlut_t [0:255];

	function automatic logic [7:0] temp_eval(input int t);
		longint c [0:6];
		longint h;
		c[0] = 64'sd727580800000000000;
		c[1] = 64'sd21489410000000000;
		c[2] = 64'sd142459300000000;
		c[3] = -64'sd2525453000000;
		c[4] = -64'sd14644470000;
		c[5] = 64'sd319369300;
		c[6] = -64'sd1160370;
		h = c[6];
		for (int i = 5; i >= 0; i--) begin
			h = h * longint'(t) + c[i];
		end
		if (h < 0) begin
			return 8'd0;
		end
		h = h / 64'sd10000000000000000;
		return (h > 255) ? 8'd255 : 8'(h);
	endfunction

	function automatic tlut_t build_tlut();
		tlut_t r;
		for (int i = 0; i < 256; i++) begin
			r[i] = temp_eval(i - 64);
		end
		return r;
	endfunction

	localparam tlut_t TEMP_LUT = build_tlut();
	localparam logic [7:0] TEMP_TOP = temp_eval(192);

	function automatic kind_t kind_of(input logic [OffW-1:0] a);
		kind_t k;
		k = KIND_PLAIN;
		if (a == 7'h1f || a == 7'h20 || a == 7'h21) begin
			k = KIND_TEMP;
		end else if (a >= 7'h22 && a <= 7'h26) begin
			k = KIND_VOLT;
		end else if (a == 7'h29 || a == 7'h2a) begin
			k = KIND_FAN;
		end
		return k;
	endfunction

	function automatic logic [SelW-1:0] sens_idx(input logic [OffW-1:0] a);
		logic [SelW-1:0] s;
		case (a)
			7'h1f: s = 4'd2;
			7'h20: s = 4'd0;
			7'h21: s = 4'd1;
			7'h22: s = 4'd3;
			7'h23: s = 4'd4;
			7'h24: s = 4'd5;
			7'h25: s = 4'd6;
			7'h26: s = 4'd7;
			7'h29: s = 4'd8;
			7'h2a: s = 4'd9;
			default: s = 4'd0;
		endcase
		return s;
	endfunction

	function automatic logic [17:0] volt_k(input logic [OffW-1:0] a);
		logic [17:0] k;
		case (a)
			7'h22: k = 18'd137783;
			7'h23: k = 18'd137783;
			7'h24: k = 18'd103131;
			7'h25: k = 18'd66242;
			7'h26: k = 18'd27338;
			default: k = 18'd0;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] reg_image(input logic [OffW-1:0] a);
		logic [7:0] v;
		case (a)
			7'h17: v = 8'h80;
			7'h3f: v = 8'ha2;
			7'h40: v = 8'h08;
			7'h47: v = 8'h50;
			7'h4b: v = 8'h15;
			default: v = 8'h00;
		endcase
		return v;
	endfunction

endpackage

>>> sv/hmr_ctrl.sv
// Sequencer of the hardware monitor read path.
// Depends on hmr_pkg and the assertion macros header.
`include "hardware_monitor_registers_macros.svh"
module hmr_ctrl
	import hmr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t st_q, st_d;
	logic [2:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (cmd.check) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 3'd1;
			end
		end
	end

	always_comb begin
		st_d = st_q;
		cmd = '0;
		s_tready = 1'b0;
		case (st_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.capture = s_tvalid;
				if (s_tvalid && sts.is_read) begin
					st_d = ST_FETCH;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				st_d = sts.direct ? ST_FINISH : ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				st_d = sts.prep_done ? ST_FINISH : ST_CHECK;
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				st_d = sts.check_done ? ST_FINISH : ST_DIV;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (cnt_q == 3'd7) begin
					st_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!sts.out_full) begin
					cmd.load_out = 1'b1;
					st_d = ST_IDLE;
				end
			end
			default: st_d = ST_IDLE;
		endcase
	end

	`HMR_ASSERT_NXT(a_finish_leaves, st_q == ST_FINISH && !sts.out_full, st_q == ST_IDLE)
	`HMR_ASSERT_NXT(a_check_divides, st_q == ST_CHECK && !sts.check_done, st_q == ST_DIV)
	`HMR_ASSERT_IMP(a_div_count, st_q != ST_DIV, cnt_q == 3'd0 || $past(st_q) == ST_DIV)

endmodule

>>> sv/hmr_dp.sv
// Datapath of the hardware monitor: register file, sensor readings,
// conversion arithmetic, shared restoring divider and output register.
// Depends on hmr_pkg and the assertion macros header.
`include "hardware_monitor_registers_macros.svh"
module hmr_dp
	import hmr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic [InW-1:0] in_word,
	input  cmd_t cmd,
	output sts_t sts,
	input  logic out_ready,
	output logic out_valid,
	output logic [7:0] out_data
);

	logic [1:0] act;
	logic [OffW-1:0] a_in;
	logic [7:0] wd;
	logic [SelW-1:0] sel;
	logic signed [SensW-1:0] val;
	assign act = in_word[1:0];
	assign a_in = in_word[8:2];
	assign wd = in_word[16:9];
	assign sel = in_word[20:17];
	assign val = $signed(in_word[37:21]);

	logic [7:0] mem [0:RegDepth-1];
	logic [RegDepth-1:0] wr_q;
	logic [7:0] r40_q, r47_q;
	logic signed [SensW-1:0] sens_q [0:NumSens-1];

	logic [OffW-1:0] off_q;
	logic [7:0] mem_rd_q;
	logic hit_q;
	logic signed [SensW-1:0] rd_q;
	logic signed [NumW-1:0] prod_q;
	logic [NumW-1:0] n_q;
	logic [DivW-1:0] d_q;
	logic [RemW-1:0] rem_q;
	logic [RemW-2:0] ds_q;
	logic [7:0] res_q;
	logic out_valid_q;
	logic [7:0] out_q;

	logic wr_en, wprot, img_rst;
	logic [7:0] wv;
	kind_t kind;
	logic signed [NumW:0] num;
	logic [1:0] fsh;
	logic [7:0] plain_v, temp_v;
	logic [7:0] tidx;

	assign kind = kind_of(off_q);
	assign wprot = a_in <= 7'h0f || a_in == 7'h3f || a_in == 7'h41 || a_in == 7'h42
		|| a_in == 7'h4a || a_in >= 7'h4c;
	assign wr_en = cmd.capture && act == ACT_WRITE && !wprot;
	assign img_rst = wr_en && a_in == 7'h40 && wd[7];
	assign wv = (a_in == 7'h48) ? {1'b0, wd[6:0]} : wd;
	assign num = (NumW+1)'(prod_q) - VOLT_OFF;
	assign fsh = (off_q == 7'h29) ? r47_q[5:4] : r47_q[7:6];
	assign tidx = 8'(rd_q + 17'sd64);

	always_comb begin
		if (off_q <= 7'h0f || off_q >= 7'h50) begin
			plain_v = r40_q;
		end else begin
			plain_v = hit_q ? mem_rd_q : reg_image(off_q);
		end
		if (rd_q >= -17'sd64 && rd_q <= 17'sd191) begin
			temp_v = TEMP_LUT[tidx];
		end else if (rd_q == 17'sd192) begin
			temp_v = TEMP_TOP;
		end else begin
			temp_v = 8'd0;
		end
	end

	always_comb begin
		sts.is_read = act == ACT_READ;
		sts.direct = kind == KIND_PLAIN || kind == KIND_TEMP;
		if (kind == KIND_VOLT) begin
			sts.prep_done = num[NumW] || num == '0;
		end else begin
			sts.prep_done = rd_q[SensW-1] || rd_q == '0;
		end
		sts.check_done = n_q >= {7'd0, d_q, 8'd0};
		sts.out_full = out_valid_q && !out_ready;
	end

	always_ff @(posedge clk) begin
		if (wr_en && !img_rst) begin
			mem[a_in] <= wv;
		end
		if (cmd.capture) begin
			mem_rd_q <= mem[a_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			r40_q <= reg_image(7'h40);
			r47_q <= reg_image(7'h47);
			for (int i = 0; i < NumSens; i++) begin
				sens_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (img_rst) begin
				wr_q <= '0;
				r40_q <= reg_image(7'h40);
				r47_q <= reg_image(7'h47);
			end else if (wr_en) begin
				wr_q[a_in] <= 1'b1;
				if (a_in == 7'h40) begin
					r40_q <= wv;
				end
				if (a_in == 7'h47) begin
					r47_q <= wv;
				end
			end
			if (cmd.capture && act == ACT_UPDATE && sel < SelW'(NumSens)) begin
				sens_q[sel] <= val;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			off_q <= a_in;
			hit_q <= wr_q[a_in];
			rd_q <= sens_q[sens_idx(a_in)];
		end
		if (cmd.fetch) begin
			res_q <= (kind == KIND_TEMP) ? temp_v : plain_v;
			prod_q <= rd_q * $signed({1'b0, volt_k(off_q)});
		end
		if (cmd.prep) begin
			if (kind == KIND_VOLT) begin
				res_q <= 8'd0;
				n_q <= NumW'(num);
				d_q <= VOLT_DIV;
			end else begin
				res_q <= rd_q[SensW-1] ? 8'd1 : 8'd0;
				n_q <= FAN_CONST;
				d_q <= DivW'({rd_q[15:0], 3'd0} >> (2'd3 - fsh));
			end
		end
		if (cmd.check) begin
			res_q <= sts.check_done ? 8'd255 : 8'd0;
			rem_q <= n_q[RemW-1:0];
			ds_q <= {d_q, 7'd0};
		end
		if (cmd.step) begin
			if (rem_q >= {1'b0, ds_q}) begin
				rem_q <= rem_q - {1'b0, ds_q};
				res_q <= {res_q[6:0], 1'b1};
			end else begin
				res_q <= {res_q[6:0], 1'b0};
			end
			ds_q <= ds_q >> 1;
		end
		if (cmd.load_out) begin
			out_q <= (kind == KIND_FAN && res_q == 8'd0 && rd_q != '0) ? 8'd1 : res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`HMR_ASSERT_NXT(a_load_shows, cmd.load_out, out_valid_q)
	`HMR_ASSERT_IMP(a_load_free, cmd.load_out, !sts.out_full)
	`HMR_ASSERT_NXT(a_img_clears, img_rst, wr_q == '0 && r47_q == 8'h50)

endmodule

>>> sv/hardware_monitor_registers.sv
// Hardware monitor register block: top level joining sequencer and datapath.
// Depends on hmr_pkg, hmr_ctrl and hmr_dp.
//
// Input channel s_*: one word per bus read, bus write or sensor update.
// Writes and sensor updates are taken while idle and give no output word.
// A read gives one byte on m_*. Plain register and temperature reads need no
// division; voltage and fan reads run the 8-step restoring divider, which is
// skipped when the value saturates or the sensor reads zero. A new word is
// accepted only once the previous read has finished; writes and updates are
// taken every cycle while no read is in progress.
// The output register holds a finished byte while m_tready is low; a new
// word is still accepted, and a following read waits in its last step
// until the held byte is taken.
// Reset restores the register reset image, clears the sensor readings and
// empties the output. A write of bit 7 to offset 0x40 restores the image
// only; sensor readings are kept.
module hardware_monitor_registers
	import hmr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// action[1:0], reg_offset[8:2], write_data[16:9], sensor_select[20:17],
	// sensor_value[37:21], zero pad[39:38]
	input  logic [InW-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// read_data[7:0]
	output logic [7:0] m_tdata
);

	cmd_t cmd;
	sts_t sts;

	hmr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts(sts),
		.cmd(cmd)
	);

	hmr_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.in_word(s_tdata),
		.cmd(cmd),
		.sts(sts),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_data(m_tdata)
	);

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for the hardware monitor register block: directed and random bus reads,
// writes and sensor updates checked against a behavioral predictor of the block.
// Depends on hmr_pkg and hardware_monitor_registers.
module testbench;
	import hmr_pkg::*;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [InW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [7:0] m_tdata;

	hardware_monitor_registers i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	logic [7:0] mon_regs [0:127];
	logic signed [16:0] mon_sens [0:9];
	logic [7:0] read_bytes_due [$];
	int mismatches;
	int send_idle_pct;
	int recv_idle_pct;

	initial begin
		clk = 1'b0;
	end

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] temp_byte(input logic signed [16:0] t);
		longint coef [0:6];
		longint h;
		coef[0] = 64'sd727580800000000000;
		coef[1] = 64'sd21489410000000000;
		coef[2] = 64'sd142459300000000;
		coef[3] = -64'sd2525453000000;
		coef[4] = -64'sd14644470000;
		coef[5] = 64'sd319369300;
		coef[6] = -64'sd1160370;
		if (t < -64 || t > 192) begin
			return 8'd0;
		end
		h = coef[6];
		for (int i = 5; i >= 0; i--) begin
			h = h * longint'(t) + coef[i];
		end
		if (h < 0) begin
			return 8'd0;
		end
		h = h / 64'sd10000000000000000;
		return (h > 255) ? 8'd255 : 8'(h);
	endfunction

	function automatic logic [7:0] volt_byte(input logic signed [16:0] mv, input int ch);
		longint k [0:4];
		longint num;
		longint q;
		k[0] = 137783; k[1] = 137783; k[2] = 103131; k[3] = 66242; k[4] = 27338;
		num = longint'(mv) * k[ch] - 64'sd7897088;
		if (num <= 0) begin
			return 8'd0;
		end
		q = num / 64'sd1638400;
		return (q > 255) ? 8'd255 : 8'(q);
	endfunction

	function automatic logic [7:0] fan_byte(input logic signed [16:0] rpm, input int shift);
		longint q;
		if (rpm == 0) begin
			return 8'd0;
		end
		if (rpm < 0) begin
			return 8'd1;
		end
		q = 64'sd1350000 / (longint'(rpm) * (longint'(1) << ((mon_regs[7'h47] >> shift) & 3)));
		if (q < 1) begin
			q = 1;
		end
		return (q > 255) ? 8'd255 : 8'(q);
	endfunction

	function automatic logic [7:0] read_byte(input logic [6:0] a);
		if (a <= 7'h0f || a >= 7'h50) begin
			return mon_regs[7'h40];
		end
		case (a)
			7'h1f: return temp_byte(mon_sens[2]);
			7'h20: return temp_byte(mon_sens[0]);
			7'h21: return temp_byte(mon_sens[1]);
			7'h29: return fan_byte(mon_sens[8], 4);
			7'h2a: return fan_byte(mon_sens[9], 6);
			default: ;
		endcase
		if (a >= 7'h22 && a <= 7'h26) begin
			return volt_byte(mon_sens[3 + int'(a - 7'h22)], int'(a - 7'h22));
		end
		return mon_regs[a];
	endfunction

	task automatic restore_image();
		for (int i = 0; i < 128; i++) begin
			mon_regs[i] = 8'h00;
		end
		mon_regs[7'h17] = 8'h80;
		mon_regs[7'h3f] = 8'ha2;
		mon_regs[7'h40] = 8'h08;
		mon_regs[7'h47] = 8'h50;
		mon_regs[7'h4b] = 8'h15;
	endtask

	task automatic predict(input act_t act, input logic [6:0] a, input logic [7:0] wd,
			input logic [3:0] sel, input logic signed [16:0] val);
		logic [7:0] v;
		v = wd;
		case (act)
			ACT_READ: read_bytes_due.push_back(read_byte(a));
			ACT_WRITE: begin
				if (!(a <= 7'h0f || a == 7'h3f || a == 7'h41 || a == 7'h42 || a == 7'h4a
						|| a >= 7'h4c)) begin
					if (a == 7'h40 && v[7]) begin
						restore_image();
					end else begin
						if (a == 7'h48) begin
							v[7] = 1'b0;
						end
						mon_regs[a] = v;
					end
				end
			end
			ACT_UPDATE: begin
				if (sel < 4'd10) begin
					mon_sens[sel] = val;
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_word(input act_t act, input logic [6:0] a, input logic [7:0] wd,
			input logic [3:0] sel, input logic signed [16:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {2'b00, val, sel, wd, a, act};
		predict(act, a, wd, sel, val);
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (read_bytes_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);
	endtask

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (read_bytes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected read byte %02h", m_tdata);
				end
			end else begin
				if (m_tdata !== read_bytes_due[0]) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("read byte mismatch: expected %02h actual %02h",
							read_bytes_due[0], m_tdata);
					end
				end
				void'(read_bytes_due.pop_front());
			end
		end
	end

	task automatic test_directed();
		int sv [0:7];
		sv[0] = -40; sv[1] = -64; sv[2] = 0; sv[3] = 192; sv[4] = 193;
		sv[5] = 65535; sv[6] = 1; sv[7] = -65536;
		for (int i = 0; i < 8; i++) begin
			send_word(ACT_UPDATE, 7'h00, 8'h00, 4'(i % 10), 17'(sv[i]));
		end
		send_word(ACT_UPDATE, 7'h00, 8'h00, 4'd8, -17'sd5);
		send_word(ACT_UPDATE, 7'h00, 8'h00, 4'd9, 17'sd1);
		send_word(ACT_UPDATE, 7'h00, 8'h00, 4'd15, 17'sd100);
		send_word(ACT_NOP, 7'h7f, 8'hff, 4'd0, 17'sd0);
		for (int a = 7'h1f; a <= 7'h2a; a++) begin
			send_word(ACT_READ, 7'(a), 8'h00, 4'd0, 17'sd0);
		end
		send_word(ACT_WRITE, 7'h48, 8'hff, 4'd0, 17'sd0);
		send_word(ACT_WRITE, 7'h3f, 8'h00, 4'd0, 17'sd0);
		send_word(ACT_READ, 7'h48, 8'h00, 4'd0, 17'sd0);
		send_word(ACT_WRITE, 7'h40, 8'h80, 4'd0, 17'sd0);
		send_word(ACT_READ, 7'h7f, 8'h00, 4'd0, 17'sd0);
		drain();
	endtask

	task automatic test_random(input int count);
		act_t act;
		logic [6:0] a;
		logic signed [16:0] val;
		for (int n = 0; n < count; n++) begin
			act = act_t'($urandom_range(3));
			if ($urandom_range(3) == 0) begin
				act = ACT_READ;
			end
			a = ($urandom_range(2) == 0) ? 7'($urandom) : 7'($urandom_range(8'h4b, 8'h10));
			if (act == ACT_WRITE && a == 7'h40 && $urandom_range(3) != 0) begin
				a = 7'h47;
			end
			case ($urandom_range(3))
				0: val = 17'($urandom_range(256) - 64);
				1: val = 17'($urandom_range(20000));
				2: val = 17'($urandom_range(65535));
				default: val = 17'($urandom);
			endcase
			send_word(act, a, 8'($urandom), 4'($urandom_range(10)), val);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		restore_image();
		for (int i = 0; i < 10; i++) begin
			mon_sens[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 23;
		recv_idle_pct = 79;
		test_random(600);
		send_idle_pct = 79;
		recv_idle_pct = 23;
		test_random(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(630);
		if (mismatches == 0 && read_bytes_due.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("tb: failure");
		$finish;
	end
endmodule

>>> files.f
+incdir+sv
sv/hmr_pkg.sv
sv/hmr_ctrl.sv
sv/hmr_dp.sv
sv/hardware_monitor_registers.sv
tb/testbench.sv
